[hdl/piecewise_linear_calibrator_unit_defines.svh]
// assertion macros for the calibrator
`ifndef PIECEWISE_LINEAR_CALIBRATOR_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_CALIBRATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// checked only out of reset
`define PLC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked at every edge, reset included
`define PLC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PLC_ASSERT(lbl, prop, msg)
`define PLC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hdl/plc_pkg.sv]
package plc_pkg;

   localparam int BREAKPOINTS = 11;
   localparam int TABLE_CAP   = 32;
   localparam int POINTS      = (BREAKPOINTS < 2) ? 2 :
                                (BREAKPOINTS > TABLE_CAP) ? TABLE_CAP : BREAKPOINTS;
   localparam int TAB_AW      = $clog2(TABLE_CAP);
   localparam int IDX_W       = $clog2(POINTS);
   localparam int LAST_POINT  = POINTS - 1;
   localparam int LAST_SEG    = POINTS - 2;

   localparam int DATA_W = 16;
   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int QUO_W  = DIFF_W;
   localparam int CNT_W  = $clog2(QUO_W);

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // measured breakpoints, 0.01 degC
   function automatic logic signed [DATA_W-1:0] meas_at(input logic [TAB_AW-1:0] idx);
      logic signed [DATA_W-1:0] v;
      case (idx)
         5'd0:    v = 16'sd0;
         5'd1:    v = 16'sd1780;
         5'd2:    v = 16'sd2150;
         5'd3:    v = 16'sd2900;
         5'd4:    v = 16'sd4300;
         5'd5:    v = 16'sd4900;
         5'd6:    v = 16'sd5600;
         5'd7:    v = 16'sd6300;
         5'd8:    v = 16'sd7000;
         5'd9:    v = 16'sd7900;
         5'd10:   v = 16'sd10000;
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

   // actual temperatures at the breakpoints, 0.01 degC
   function automatic logic signed [DATA_W-1:0] act_at(input logic [TAB_AW-1:0] idx);
      logic signed [DATA_W-1:0] v;
      case (idx)
         5'd0:    v = 16'sd0;
         5'd1:    v = 16'sd1640;
         5'd2:    v = 16'sd2070;
         5'd3:    v = 16'sd3100;
         5'd4:    v = 16'sd4350;
         5'd5:    v = 16'sd5080;
         5'd6:    v = 16'sd6050;
         5'd7:    v = 16'sd6500;
         5'd8:    v = 16'sd7120;
         5'd9:    v = 16'sd8150;
         5'd10:   v = 16'sd10000;
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

endpackage

[hdl/plc_divider.sv]
module plc_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [plc_pkg::PROD_W-1:0]   dividend,
   input  logic [plc_pkg::DIFF_W-1:0]   divisor,
   output logic [plc_pkg::QUO_W-1:0]    quotient,
   output plc_pkg::div_stat_type        stat
);
   import plc_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DIFF_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]    low_ff, low_in;
   logic [DIFF_W+1:0]   trial;
   logic                last_step;

   // shift in the next dividend bit and try the subtract
   assign trial     = {1'b0, rem_ff, low_ff[QUO_W-1]} - {2'b00, divisor};
   assign last_step = (cnt_ff == CNT_W'(QUO_W - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      if (start) begin
         // quotient fits QUO_W bits, so the upper dividend bits are below the divisor
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[PROD_W-1:QUO_W];
         low_in  = dividend[QUO_W-1:0];
      end else if (busy_ff) begin
         if (trial[DIFF_W+1]) begin
            rem_in = {rem_ff[DIFF_W-2:0], low_ff[QUO_W-1]};
            low_in = {low_ff[QUO_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DIFF_W-1:0];
            low_in = {low_ff[QUO_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign quotient  = low_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[hdl/piecewise_linear_calibrator_unit.sv]
// Piecewise linear temperature calibrator. Each req_ word carries one measured
// temperature (signed, 0.01 degC); each rsp_ word returns the calibrated value
// interpolated over a fixed table of measured/actual breakpoints, clamped to the
// end values outside the table. One word is worked on at a time: req_ready is
// high only while the sequencer is idle. The segment search compares one segment
// per cycle, and the shift-subtract divider retires one quotient bit per cycle.
// The next word can be accepted in the cycle after the result is written.
// A finished result sits in the rsp_ output register, so the next word can be
// accepted while the previous one waits to be taken.
`include "piecewise_linear_calibrator_unit_defines.svh"

module piecewise_linear_calibrator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [plc_pkg::DATA_W-1:0]   req_measured_temp,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [plc_pkg::DATA_W-1:0]   rsp_calibrated_temp
);
   import plc_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_LOAD   = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_FIN    = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic signed [DATA_W-1:0]   x_ff, x_in;
   logic signed [DATA_W-1:0]   a0_ff, a0_in;
   logic signed [DIFF_W-1:0]   da_ff, da_in;
   logic signed [DIFF_W-1:0]   dxoff_ff, dxoff_in;
   logic [DIFF_W-1:0]          dx_ff, dx_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [DATA_W-1:0]   result_ff, result_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   rsp_temp_ff, rsp_temp_in;

   logic                       req_accept;
   logic [TAB_AW-1:0]          seg_lo, seg_hi;
   logic signed [DATA_W-1:0]   m0, m1, a1;
   logic signed [DIFF_W-1:0]   seg_dx;
   logic                       in_seg;
   logic [PROD_W-1:0]          prod_mag;
   logic                       prod_neg;
   logic signed [DIFF_W:0]     quo_signed;
   logic signed [DIFF_W:0]     sum;
   logic signed [DATA_W-1:0]   sum_sat;
   logic                       div_start;
   logic [QUO_W-1:0]           quotient;
   div_stat_type               div_stat;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   // one segment of the table under test
   assign seg_lo = TAB_AW'(idx_ff);
   assign seg_hi = seg_lo + TAB_AW'(1);
   assign m0     = meas_at(seg_lo);
   assign m1     = meas_at(seg_hi);
   assign a1     = act_at(seg_hi);
   assign seg_dx = DIFF_W'(m1) - DIFF_W'(m0);
   assign in_seg = (x_ff >= m0) && (x_ff <= m1);

   // divider sees the magnitude, sign is restored afterwards
   assign prod_neg  = prod_ff[PROD_W-1];
   assign prod_mag  = prod_neg ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign div_start = (state_ff == ST_LOAD);

   plc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mag),
      .divisor  (dx_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   // truncating quotient, then offset and saturate
   assign quo_signed = prod_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
   assign sum        = (DIFF_W+1)'(a0_ff) + quo_signed;
   always_comb begin
      if (sum > (DIFF_W+1)'(32767)) begin
         sum_sat = 16'sh7fff;
      end else if (sum < -(DIFF_W+1)'(32768)) begin
         sum_sat = 16'sh8000;
      end else begin
         sum_sat = sum[DATA_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      x_in         = x_ff;
      a0_in        = a0_ff;
      da_in        = da_ff;
      dxoff_in     = dxoff_ff;
      dx_in        = dx_ff;
      prod_in      = prod_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_temp_in  = rsp_temp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               x_in     = req_measured_temp;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // clamp below the first and above the last breakpoint
            if (x_ff <= meas_at(TAB_AW'(0))) begin
               result_in = act_at(TAB_AW'(0));
               state_in  = ST_FIN;
            end else if (x_ff >= meas_at(TAB_AW'(LAST_POINT))) begin
               result_in = act_at(TAB_AW'(LAST_POINT));
               state_in  = ST_FIN;
            end else begin
               idx_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (in_seg) begin
               a0_in    = act_at(seg_lo);
               da_in    = DIFF_W'(a1) - DIFF_W'(act_at(seg_lo));
               dxoff_in = DIFF_W'(x_ff) - DIFF_W'(m0);
               dx_in    = seg_dx;
               if (seg_dx <= 0) begin
                  // zero-width segment gives the left actual value
                  result_in = act_at(seg_lo);
                  state_in  = ST_FIN;
               end else begin
                  state_in = ST_MUL;
               end
            end else if (idx_ff == IDX_W'(LAST_SEG)) begin
               // no segment matched
               result_in = act_at(TAB_AW'(LAST_POINT));
               state_in  = ST_FIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_MUL: begin
            prod_in  = da_ff * dxoff_ff;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               result_in = sum_sat;
               state_in  = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      x_ff        <= x_in;
      a0_ff       <= a0_in;
      da_ff       <= da_in;
      dxoff_ff    <= dxoff_in;
      dx_ff       <= dx_in;
      prod_ff     <= prod_in;
      result_ff   <= result_in;
      rsp_temp_ff <= rsp_temp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_calibrated_temp = rsp_temp_ff;

   // an accepted word keeps the block busy on the next cycle
   `PLC_ASSERT(a_busy_after_accept, req_accept |=> !req_ready, "ready right after accept")
   // divider finishes only while the sequencer waits for it
   `PLC_ASSERT(a_div_done_in_div, div_stat.done |-> (state_ff == ST_DIV), "stray divide done")
   // a new result appears only out of the finish state
   `PLC_ASSERT(a_rsp_from_fin, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN),
      "result without finish")
   // the divider never runs while the sequencer is idle
   `PLC_ASSERT_ALWAYS(a_div_idle, (state_ff == ST_IDLE) |-> !div_stat.busy,
      "divider busy while idle")

endmodule
